@@ rtl/core/rei_pkg.sv @@
package rei_pkg;

  localparam int RAD_W     = 47;
  localparam int HGT_W     = 40;
  localparam int RSUM_W    = 49;
  localparam int CFG_IDX_W = 2;
  localparam int MUL_DIG   = 16;

  localparam int DEFAULT_COORD_W = 48;
  localparam int DEFAULT_DIR_W   = 32;

  localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(256);

  localparam logic [CFG_IDX_W-1:0] CFG_EQUATOR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POLAR   = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_MISS = 2'd1,
    ST_ZERO = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

@@ rtl/core/rei_delay.sv @@
module rei_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [0:N-1];

  always_ff @(posedge clk) begin
    sr_r[0] <= d;
  end

  for (genvar i = 1; i < N; i++) begin : g_tap
    always_ff @(posedge clk) begin
      sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[N-1];

endmodule

@@ rtl/core/rei_mul.sv @@
// Signed multiplier, one 16-bit digit of b per stage, then a registered sign fix.
module rei_mul #(
  parameter int WA = 16,
  parameter int WB = 16
) (
  input  logic                    clk,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int DIG = rei_pkg::MUL_DIG;
  localparam int ND  = (WB + DIG - 1) / DIG;
  localparam int WBP = ND * DIG;
  localparam int PW  = WA + WBP;

  logic [WA-1:0]        ma_c;
  logic [WB-1:0]        mb_c;
  logic [WA-1:0]        ma_r  [0:ND-1];
  logic [WBP-1:0]       mb_r  [0:ND-1];
  logic                 neg_r [0:ND];
  logic [PW-1:0]        acc_r [0:ND];
  logic [WA+WB-1:0]     mag_c;
  logic signed [WA+WB-1:0] p_r;

  assign ma_c = a[WA-1] ? WA'(-a) : WA'(a);
  assign mb_c = b[WB-1] ? WB'(-b) : WB'(b);

  always_ff @(posedge clk) begin
    ma_r[0]  <= ma_c;
    mb_r[0]  <= WBP'(mb_c);
    neg_r[0] <= a[WA-1] ^ b[WB-1];
    acc_r[0] <= '0;
  end

  for (genvar k = 1; k <= ND; k++) begin : g_dig
    logic [WA+DIG-1:0] pp;
    assign pp = ma_r[k-1] * mb_r[k-1][DIG*(k-1) +: DIG];
    always_ff @(posedge clk) begin
      neg_r[k] <= neg_r[k-1];
      acc_r[k] <= acc_r[k-1] + (PW'(pp) << (DIG*(k-1)));
    end
    if (k < ND) begin : g_pass
      always_ff @(posedge clk) begin
        ma_r[k] <= ma_r[k-1];
        mb_r[k] <= mb_r[k-1];
      end
    end
  end

  assign mag_c = acc_r[ND][WA+WB-1:0];

  always_ff @(posedge clk) begin
    p_r <= neg_r[ND] ? -signed'(mag_c) : signed'(mag_c);
  end

  assign p = p_r;

endmodule

@@ rtl/core/rei_isqrt.sv @@
// Floor square root, one root bit per stage.
module rei_isqrt #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic [W-1:0]   rad,
  output logic [W/2-1:0] root
);

  localparam int N = W / 2;

  logic [W-1:0]   rad_r  [0:N-1];
  logic [N-1:0]   root_r [0:N-1];
  logic [N+1:0]   rem_r  [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [W-1:0] rad_i;
    logic [N-1:0] root_i;
    logic [N+1:0] rem_i;
    logic [N+3:0] remx;
    logic [N+3:0] trial;
    if (k == 0) begin : g_first
      assign rad_i  = rad;
      assign root_i = '0;
      assign rem_i  = '0;
    end else begin : g_next
      assign rad_i  = rad_r[k-1];
      assign root_i = root_r[k-1];
      assign rem_i  = rem_r[k-1];
    end
    assign remx  = {rem_i, rad_i[W-1:W-2]};
    assign trial = (N+4)'({root_i, 2'b01});
    always_ff @(posedge clk) begin
      rad_r[k] <= rad_i << 2;
      if (remx >= trial) begin
        rem_r[k]  <= (N+2)'(remx - trial);
        root_r[k] <= {root_i[N-2:0], 1'b1};
      end else begin
        rem_r[k]  <= (N+2)'(remx);
        root_r[k] <= {root_i[N-2:0], 1'b0};
      end
    end
  end

  assign root = root_r[N-1];

endmodule

@@ rtl/core/rei_div.sv @@
// Restoring divider, one quotient bit per stage.
// ovf flags a quotient that does not fit in QB bits.
module rei_div #(
  parameter int NW = 16,
  parameter int VW = 8,
  parameter int QB = 8
) (
  input  logic          clk,
  input  logic [NW-1:0] n,
  input  logic [VW-1:0] v,
  output logic [QB-1:0] q,
  output logic          ovf
);

  logic [VW+QB-1:0] vsh_c;
  logic [NW-1:0]    rem_r [0:QB];
  logic [VW-1:0]    v_r   [0:QB-1];
  logic [QB-1:0]    q_r   [0:QB];
  logic             ovf_r [0:QB];

  assign vsh_c = (VW+QB)'(v) << QB;

  always_ff @(posedge clk) begin
    rem_r[0] <= n;
    v_r[0]   <= v;
    q_r[0]   <= '0;
    ovf_r[0] <= (n >= vsh_c);
  end

  for (genvar k = 1; k <= QB; k++) begin : g_bit
    logic [VW+QB-1:0] trial;
    assign trial = (VW+QB)'(v_r[k-1]) << (QB - k);
    always_ff @(posedge clk) begin
      ovf_r[k] <= ovf_r[k-1];
      if (rem_r[k-1] >= trial) begin
        rem_r[k]        <= NW'(rem_r[k-1] - trial);
        q_r[k]          <= q_r[k-1] | (QB'(1) << (QB - k));
      end else begin
        rem_r[k]        <= rem_r[k-1];
        q_r[k]          <= q_r[k-1];
      end
    end
    if (k < QB) begin : g_pass
      always_ff @(posedge clk) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  assign q   = q_r[QB];
  assign ovf = ovf_r[QB];

endmodule

@@ rtl/core/ray_ellipsoid_intersect_unit.sv @@
// Ray / biaxial ellipsoid intersection. Each item (origin, direction, height)
// yields exactly one result (hit point, status). A new item can be started
// in every cycle; busy is high only during reset. The result is shown for one
// cycle under out_valid and must be taken then. Latency is set by the 16-bit
// digit multipliers, the square root (one root bit per stage, about half the
// discriminant width) and the divider (COORD_WIDTH+3 stages). Write the radius
// registers only while no item is in flight.
module ray_ellipsoid_intersect_unit #(
  parameter int COORD_WIDTH = rei_pkg::DEFAULT_COORD_W,
  parameter int DIR_WIDTH   = rei_pkg::DEFAULT_DIR_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COORD_WIDTH-1:0]  in_origin_x,
  input  logic signed [COORD_WIDTH-1:0]  in_origin_y,
  input  logic signed [COORD_WIDTH-1:0]  in_origin_z,
  input  logic signed [DIR_WIDTH-1:0]    in_dir_x,
  input  logic signed [DIR_WIDTH-1:0]    in_dir_y,
  input  logic signed [DIR_WIDTH-1:0]    in_dir_z,
  input  logic signed [rei_pkg::HGT_W-1:0] in_surface_height,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rei_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rei_pkg::RAD_W-1:0]      cfg_data,
  output logic                           out_valid,
  output logic signed [COORD_WIDTH-1:0]  out_hit_x,
  output logic signed [COORD_WIDTH-1:0]  out_hit_y,
  output logic signed [COORD_WIDTH-1:0]  out_hit_z,
  output logic [1:0]                     out_status
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = DIR_WIDTH;
  localparam int RW = rei_pkg::RSUM_W;
  localparam int DG = rei_pkg::MUL_DIG;

  // operand and result widths of each phase
  localparam int W1     = rei_pkg::imax(RW, rei_pkg::imax(CW, DW));
  localparam int L1     = (W1 + DG - 1) / DG + 2;
  localparam int SQR_W  = 2 * RW;
  localparam int DD_W   = 2 * DW + 1;
  localparam int DO_W   = CW + DW + 1;
  localparam int OO_W   = 2 * CW + 1;
  localparam int WA2    = rei_pkg::imax(SQR_W, rei_pkg::imax(DD_W, rei_pkg::imax(DO_W, OO_W)));
  localparam int WB2    = SQR_W;
  localparam int L2     = (WB2 + DG - 1) / DG + 2;
  localparam int AQ_W   = DD_W + SQR_W + 1;
  localparam int HB_W   = DO_W + SQR_W + 1;
  localparam int C_W    = WA2 + WB2 + 2;
  localparam int WA3    = rei_pkg::imax(HB_W, AQ_W);
  localparam int WB3    = rei_pkg::imax(HB_W, C_W);
  localparam int L3     = (WB3 + DG - 1) / DG + 2;
  localparam int D_W    = WA3 + WB3 + 1;
  localparam int SQI_W  = 2 * (D_W / 2);
  localparam int S_W    = SQI_W / 2;
  localparam int NUM_W  = rei_pkg::imax(HB_W, S_W + 1) + 1;
  localparam int L6     = (DW + DG - 1) / DG + 2;
  localparam int P6_W   = NUM_W + DW;
  localparam int NW     = P6_W + 1;
  localparam int QB     = CW + 2;
  localparam int SUM_W  = CW + 4;

  // pipeline timeline, in cycles after start
  localparam int T0  = 1;
  localparam int T1  = T0 + L1;
  localparam int T1S = T1 + 1;
  localparam int T2  = T1S + L2;
  localparam int T2S = T2 + 1;
  localparam int T3  = T2S + L3;
  localparam int T3S = T3 + 1;
  localparam int T4  = T3S + S_W;
  localparam int T5  = T4 + 1;
  localparam int T6  = T5 + L6;
  localparam int T7  = T6 + QB + 1;
  localparam int LATENCY = T7 + 1;

  localparam logic signed [SUM_W-1:0] SMAX = signed'(SUM_W'(1) << (CW - 1)) - 1;
  localparam logic signed [SUM_W-1:0] SMIN = -SMAX - 1;

  logic accept;
  logic [LATENCY-1:0] vld_r;

  logic [rei_pkg::RAD_W-1:0] eq_rad_r;
  logic [rei_pkg::RAD_W-1:0] pol_rad_r;

  // stage 0
  logic signed [CW-1:0] o_r [0:2];
  logic signed [DW-1:0] d_r [0:2];
  logic signed [RW-1:0] ra_r;
  logic signed [RW-1:0] rb_r;
  logic                 zdir_r;

  assign accept    = start && !busy;
  assign busy      = !rst_n;
  assign cfg_ready = 1'b1;

  // radius registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eq_rad_r  <= rei_pkg::RAD_RESET;
      pol_rad_r <= rei_pkg::RAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rei_pkg::CFG_EQUATOR) begin
        eq_rad_r <= cfg_data;
      end
      if (cfg_index == rei_pkg::CFG_POLAR) begin
        pol_rad_r <= cfg_data;
      end
    end
  end

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LATENCY-2:0], accept};
    end
  end

  // register the item, form the grown radii
  always_ff @(posedge clk) begin
    o_r[0] <= in_origin_x;
    o_r[1] <= in_origin_y;
    o_r[2] <= in_origin_z;
    d_r[0] <= in_dir_x;
    d_r[1] <= in_dir_y;
    d_r[2] <= in_dir_z;
    ra_r   <= signed'({2'b00, eq_rad_r}) + RW'(in_surface_height);
    rb_r   <= signed'({2'b00, pol_rad_r}) + RW'(in_surface_height);
    zdir_r <= (in_dir_x == '0) && (in_dir_y == '0) && (in_dir_z == '0);
  end

  // phase 1: squares and cross products of the inputs
  logic signed [W1-1:0]   m1a [0:10];
  logic signed [W1-1:0]   m1b [0:10];
  logic signed [2*W1-1:0] p1  [0:10];

  assign m1a[0]  = W1'(ra_r);   assign m1b[0]  = W1'(ra_r);
  assign m1a[1]  = W1'(rb_r);   assign m1b[1]  = W1'(rb_r);
  assign m1a[2]  = W1'(d_r[0]); assign m1b[2]  = W1'(d_r[0]);
  assign m1a[3]  = W1'(d_r[1]); assign m1b[3]  = W1'(d_r[1]);
  assign m1a[4]  = W1'(d_r[2]); assign m1b[4]  = W1'(d_r[2]);
  assign m1a[5]  = W1'(d_r[0]); assign m1b[5]  = W1'(o_r[0]);
  assign m1a[6]  = W1'(d_r[1]); assign m1b[6]  = W1'(o_r[1]);
  assign m1a[7]  = W1'(d_r[2]); assign m1b[7]  = W1'(o_r[2]);
  assign m1a[8]  = W1'(o_r[0]); assign m1b[8]  = W1'(o_r[0]);
  assign m1a[9]  = W1'(o_r[1]); assign m1b[9]  = W1'(o_r[1]);
  assign m1a[10] = W1'(o_r[2]); assign m1b[10] = W1'(o_r[2]);

  for (genvar i = 0; i < 11; i++) begin : g_m1
    rei_mul #(.WA(W1), .WB(W1)) u_mul (
      .clk (clk),
      .a   (m1a[i]),
      .b   (m1b[i]),
      .p   (p1[i])
    );
  end

  logic signed [SQR_W-1:0] a2_r, b2_r;
  logic signed [DD_W-1:0]  sdd_r, dz2_r;
  logic signed [DO_W-1:0]  sdo_r, dzoz_r;
  logic signed [OO_W-1:0]  soo_r, oz2_r;

  always_ff @(posedge clk) begin
    a2_r   <= SQR_W'(p1[0]);
    b2_r   <= SQR_W'(p1[1]);
    sdd_r  <= DD_W'(p1[2]) + DD_W'(p1[3]);
    dz2_r  <= DD_W'(p1[4]);
    sdo_r  <= DO_W'(p1[5]) + DO_W'(p1[6]);
    dzoz_r <= DO_W'(p1[7]);
    soo_r  <= OO_W'(p1[8]) + OO_W'(p1[9]);
    oz2_r  <= OO_W'(p1[10]);
  end

  // phase 2: weight by the squared radii
  logic signed [WA2-1:0]     m2a [0:6];
  logic signed [WB2-1:0]     m2b [0:6];
  logic signed [WA2+WB2-1:0] p2  [0:6];

  assign m2a[0] = WA2'(sdd_r);  assign m2b[0] = b2_r;
  assign m2a[1] = WA2'(dz2_r);  assign m2b[1] = a2_r;
  assign m2a[2] = WA2'(sdo_r);  assign m2b[2] = b2_r;
  assign m2a[3] = WA2'(dzoz_r); assign m2b[3] = a2_r;
  assign m2a[4] = WA2'(soo_r);  assign m2b[4] = b2_r;
  assign m2a[5] = WA2'(oz2_r);  assign m2b[5] = a2_r;
  assign m2a[6] = WA2'(a2_r);   assign m2b[6] = b2_r;

  for (genvar i = 0; i < 7; i++) begin : g_m2
    rei_mul #(.WA(WA2), .WB(WB2)) u_mul (
      .clk (clk),
      .a   (m2a[i]),
      .b   (m2b[i]),
      .p   (p2[i])
    );
  end

  logic signed [AQ_W-1:0] a_c;
  logic signed [AQ_W-1:0] a_r;
  logic signed [HB_W-1:0] hb_r;
  logic signed [C_W-1:0]  c_r;
  logic                   azero_r;

  assign a_c = AQ_W'(p2[0]) + AQ_W'(p2[1]);

  always_ff @(posedge clk) begin
    a_r     <= a_c;
    hb_r    <= HB_W'(p2[2]) + HB_W'(p2[3]);
    c_r     <= C_W'(p2[4]) + C_W'(p2[5]) - C_W'(p2[6]);
    azero_r <= (a_c == '0);
  end

  // phase 3: discriminant terms
  logic signed [WA3-1:0]     m3a [0:1];
  logic signed [WB3-1:0]     m3b [0:1];
  logic signed [WA3+WB3-1:0] p3  [0:1];

  assign m3a[0] = WA3'(hb_r); assign m3b[0] = WB3'(hb_r);
  assign m3a[1] = WA3'(a_r);  assign m3b[1] = WB3'(c_r);

  for (genvar i = 0; i < 2; i++) begin : g_m3
    rei_mul #(.WA(WA3), .WB(WB3)) u_mul (
      .clk (clk),
      .a   (m3a[i]),
      .b   (m3b[i]),
      .p   (p3[i])
    );
  end

  logic signed [D_W-1:0] disc_c;
  logic [SQI_W-1:0]      dcl_r;
  logic                  miss_r;

  assign disc_c = D_W'(p3[0]) - D_W'(p3[1]);

  // clamp a negative discriminant to zero: nearest point on the ray
  always_ff @(posedge clk) begin
    miss_r <= disc_c[D_W-1];
    dcl_r  <= disc_c[D_W-1] ? '0 : SQI_W'(disc_c);
  end

  // phase 4: square root
  logic [S_W-1:0] s_c;

  rei_isqrt #(.W(SQI_W)) u_sqrt (
    .clk  (clk),
    .rad  (dcl_r),
    .root (s_c)
  );

  // phase 5: numerator of the nearer root
  logic signed [HB_W-1:0]  hb_d;
  logic signed [NUM_W-1:0] num_r;

  rei_delay #(.W(HB_W), .N(T4 - T2S)) u_dly_hb (
    .clk (clk),
    .d   (hb_r),
    .q   (hb_d)
  );

  always_ff @(posedge clk) begin
    num_r <= -NUM_W'(hb_d) - NUM_W'(signed'({1'b0, s_c}));
  end

  // side band: origin, direction, flags
  logic signed [CW-1:0] o_d  [0:2];
  logic signed [DW-1:0] d_d  [0:2];
  logic [AQ_W-1:0]      a_d;
  logic                 zdir_d, azero_d, miss_d;

  for (genvar i = 0; i < 3; i++) begin : g_side
    rei_delay #(.W(CW), .N(T7 - T0)) u_dly_o (
      .clk (clk),
      .d   (o_r[i]),
      .q   (o_d[i])
    );
    rei_delay #(.W(DW), .N(T5 - T0)) u_dly_d (
      .clk (clk),
      .d   (d_r[i]),
      .q   (d_d[i])
    );
  end

  rei_delay #(.W(AQ_W), .N(T6 - T2S)) u_dly_a (
    .clk (clk),
    .d   (a_r),
    .q   (a_d)
  );

  rei_delay #(.W(1), .N(T7 - T0)) u_dly_zdir (
    .clk (clk),
    .d   (zdir_r),
    .q   (zdir_d)
  );

  rei_delay #(.W(1), .N(T7 - T2S)) u_dly_azero (
    .clk (clk),
    .d   (azero_r),
    .q   (azero_d)
  );

  rei_delay #(.W(1), .N(T7 - T3S)) u_dly_miss (
    .clk (clk),
    .d   (miss_r),
    .q   (miss_d)
  );

  // phase 6 and 7: scale each direction, divide by a with rounding
  logic [QB-1:0] q_c   [0:2];
  logic          ovf_c [0:2];
  logic          neg_d [0:2];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [P6_W-1:0] prod;
    logic [P6_W-1:0]        mag;

    rei_mul #(.WA(NUM_W), .WB(DW)) u_mul (
      .clk (clk),
      .a   (num_r),
      .b   (d_d[i]),
      .p   (prod)
    );

    assign mag = prod[P6_W-1] ? P6_W'(-prod) : P6_W'(prod);

    // divide twice the magnitude: the extra quotient bit rounds half away
    rei_div #(.NW(NW), .VW(AQ_W), .QB(QB)) u_div (
      .clk (clk),
      .n   ({mag, 1'b0}),
      .v   (a_d),
      .q   (q_c[i]),
      .ovf (ovf_c[i])
    );

    rei_delay #(.W(1), .N(QB + 1)) u_dly_neg (
      .clk (clk),
      .d   (prod[P6_W-1]),
      .q   (neg_d[i])
    );
  end

  // final stage: add to origin, saturate, pick status
  logic signed [CW-1:0] hit_c [0:2];
  logic [2:0]           sat_c;
  rei_pkg::status_t     st_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [QB:0]             qr;
      logic signed [SUM_W-1:0] sum;
      qr  = ((QB+1)'(q_c[i]) + (QB+1)'(1)) >> 1;
      sum = SUM_W'(o_d[i]) + (neg_d[i] ? -SUM_W'(signed'({1'b0, qr}))
                                       :  SUM_W'(signed'({1'b0, qr})));
      if (ovf_c[i]) begin
        sat_c[i] = 1'b1;
        hit_c[i] = neg_d[i] ? CW'(SMIN) : CW'(SMAX);
      end else if (sum > SMAX) begin
        sat_c[i] = 1'b1;
        hit_c[i] = CW'(SMAX);
      end else if (sum < SMIN) begin
        sat_c[i] = 1'b1;
        hit_c[i] = CW'(SMIN);
      end else begin
        sat_c[i] = 1'b0;
        hit_c[i] = CW'(sum);
      end
    end

    priority if (zdir_d) begin
      st_c = rei_pkg::ST_ZERO;
    end else if (azero_d) begin
      st_c = rei_pkg::ST_MISS;
    end else if (sat_c != '0) begin
      st_c = rei_pkg::ST_SAT;
    end else if (miss_d) begin
      st_c = rei_pkg::ST_MISS;
    end else begin
      st_c = rei_pkg::ST_HIT;
    end
  end

  logic signed [CW-1:0] hit_x_r, hit_y_r, hit_z_r;
  logic [1:0]           status_r;
  logic                 pass_o;

  // degenerate cases give back the origin
  assign pass_o = zdir_d || azero_d;

  always_ff @(posedge clk) begin
    hit_x_r  <= pass_o ? o_d[0] : hit_c[0];
    hit_y_r  <= pass_o ? o_d[1] : hit_c[1];
    hit_z_r  <= pass_o ? o_d[2] : hit_c[2];
    status_r <= st_c;
  end

  assign out_valid  = vld_r[LATENCY-1];
  assign out_hit_x  = hit_x_r;
  assign out_hit_y  = hit_y_r;
  assign out_hit_z  = hit_z_r;
  assign out_status = status_r;

endmodule

@@ rtl/core/rei_checker.sv @@
module rei_checker #(
  parameter int CW  = rei_pkg::DEFAULT_COORD_W,
  parameter int DW  = rei_pkg::DEFAULT_DIR_W,
  parameter int LAT = 2
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic signed [DW-1:0]  in_dir_x,
  input logic signed [DW-1:0]  in_dir_y,
  input logic signed [DW-1:0]  in_dir_z,
  input logic                  out_valid,
  input logic signed [CW-1:0]  out_hit_x,
  input logic signed [CW-1:0]  out_hit_y,
  input logic signed [CW-1:0]  out_hit_z,
  input logic [1:0]            out_status
);

  localparam logic signed [CW-1:0] HMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] HMIN = {1'b1, {(CW-1){1'b0}}};

  // one result per item, a fixed latency later
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start && !busy, LAT))
    else $error("result strobe does not match item taken LAT cycles earlier");

  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == rei_pkg::ST_ZERO) |->
      $past(in_dir_x == '0 && in_dir_y == '0 && in_dir_z == '0, LAT))
    else $error("zero-direction status on an item with nonzero direction");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == rei_pkg::ST_SAT) |->
      (out_hit_x == HMAX || out_hit_x == HMIN ||
       out_hit_y == HMAX || out_hit_y == HMIN ||
       out_hit_z == HMAX || out_hit_z == HMIN))
    else $error("saturated status without any coordinate at a bound");

endmodule

bind ray_ellipsoid_intersect_unit rei_checker #(
  .CW  (COORD_WIDTH),
  .DW  (DIR_WIDTH),
  .LAT (LATENCY)
) u_rei_checker (.*);

@@ tb/ray_ellipsoid_intersect_unit_tb.sv @@
`timescale 1ns / 100ps

module ray_ellipsoid_intersect_unit_tb;
  import rei_pkg::*;

  localparam int CW = DEFAULT_COORD_W;
  localparam int DW = DEFAULT_DIR_W;
  localparam int PIPE_CYCLES = 280;
  localparam int DRAIN_CYCLES = PIPE_CYCLES + 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 260;
  // the index port is wider than the register file; writes here are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(2);

  typedef logic signed [511:0] wide_t;

  typedef struct {
    logic signed [CW-1:0]    ox, oy, oz;
    logic signed [DW-1:0]    dx, dy, dz;
    logic signed [HGT_W-1:0] h;
  } ray_t;

  typedef struct {
    logic signed [CW-1:0] hx, hy, hz;
    status_t              st;
  } ground_t;

  typedef struct {
    ray_t    ray;
    bit      typed;
    ground_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [DW-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [HGT_W-1:0] in_surface_height = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RAD_W-1:0] cfg_data = '0;
  logic out_valid;
  logic signed [CW-1:0] out_hit_x, out_hit_y, out_hit_z;
  logic [1:0] out_status;

  ray_ellipsoid_intersect_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the radius registers
  logic [RAD_W-1:0] eq_rad = RAD_RESET;
  logic [RAD_W-1:0] pol_rad = RAD_RESET;

  ground_t pending_hits[$];
  int fail_count = 0;
  int cycle_count = 0;
  int burst_left = 0;

  // floor square root; the quarter discriminant stays well below 2^366
  function automatic wide_t isqrt(wide_t v);
    wide_t r, c;
    r = '0;
    for (int i = 183; i >= 0; i--) begin
      c = r | (wide_t'(1) <<< i);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // exact ground point of a ray on the grown ellipsoid
  function automatic ground_t ground_point(ray_t r);
    wide_t o[3], d[3], ra, rb, a2, b2, a, hb, c, disc, s, num, p, mag, q, rem, res;
    wide_t maxc, minc, hh;
    ground_t g;
    bit neg;
    o[0] = wide_t'(r.ox); o[1] = wide_t'(r.oy); o[2] = wide_t'(r.oz);
    d[0] = wide_t'(r.dx); d[1] = wide_t'(r.dy); d[2] = wide_t'(r.dz);
    hh = wide_t'(r.h);
    ra = wide_t'(eq_rad);
    rb = wide_t'(pol_rad);
    ra = ra + hh;
    rb = rb + hh;
    a2 = ra * ra;
    b2 = rb * rb;
    g.hx = r.ox; g.hy = r.oy; g.hz = r.oz;
    if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
      g.st = ST_ZERO;
      return g;
    end
    a = b2 * (d[0] * d[0] + d[1] * d[1]) + a2 * d[2] * d[2];
    hb = b2 * (d[0] * o[0] + d[1] * o[1]) + a2 * d[2] * o[2];
    c = b2 * (o[0] * o[0] + o[1] * o[1]) + a2 * o[2] * o[2] - a2 * b2;
    if (a == 0) begin
      g.st = ST_MISS;
      return g;
    end
    g.st = ST_HIT;
    disc = hb * hb - a * c;
    if (disc < 0) begin
      disc = '0;
      g.st = ST_MISS;
    end
    s = isqrt(disc);
    num = -hb - s;
    maxc = (wide_t'(1) <<< (CW - 1)) - 1;
    minc = -(wide_t'(1) <<< (CW - 1));
    for (int i = 0; i < 3; i++) begin
      p = d[i] * num;
      neg = p < 0;
      mag = neg ? -p : p;
      q = mag / a;
      rem = mag % a;
      if (2 * rem >= a) q = q + 1;
      if (neg) q = -q;
      res = o[i] + q;
      if (res > maxc) begin
        res = maxc;
        g.st = ST_SAT;
      end
      if (res < minc) begin
        res = minc;
        g.st = ST_SAT;
      end
      case (i)
        0: g.hx = res[CW-1:0];
        1: g.hy = res[CW-1:0];
        default: g.hz = res[CW-1:0];
      endcase
    end
    return g;
  endfunction

  // drive one item, hold it until taken, then maybe open a gap
  task automatic send_ray(ray_t r, bit typed, ground_t want);
    int gap;
    in_origin_x <= r.ox;
    in_origin_y <= r.oy;
    in_origin_z <= r.oz;
    in_dir_x <= r.dx;
    in_dir_y <= r.dy;
    in_dir_z <= r.dz;
    in_surface_height <= r.h;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_hits.push_back(typed ? want : ground_point(r));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // drop start, let every item in flight come out, then sit out the pipe
  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one write, then cfg_valid drops before the next
  task automatic write_radius(logic [CFG_IDX_W-1:0] idx, logic [RAD_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_EQUATOR) eq_rad = val;
    else if (idx == CFG_POLAR) pol_rad = val;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly rays aimed near the body with random content, some with zero or tiny directions, the rest raw noise
  function automatic ray_t random_ray();
    ray_t r;
    logic signed [63:0] span, tx, ty, tz;
    int sh, kind;
    kind = $urandom_range(0, 19);
    r.ox = CW'(rand64()); r.oy = CW'(rand64()); r.oz = CW'(rand64());
    r.dx = $urandom(); r.dy = $urandom(); r.dz = $urandom();
    r.h = HGT_W'(rand64());
    if (kind < 13) begin
      span = {17'b0, (eq_rad > pol_rad ? eq_rad : pol_rad)};
      span = span * $urandom_range(1, 4);
      r.ox = CW'($signed(rand64() % (2 * span + 1)) - span);
      r.oy = CW'($signed(rand64() % (2 * span + 1)) - span);
      r.oz = CW'($signed(rand64() % (2 * span + 1)) - span);
      r.ox = CW'((r.ox < 0) ? r.ox - span : r.ox + span);
      // aim toward a random point near the body
      tx = $signed(rand64() % (span + 1)) - span / 2;
      ty = $signed(rand64() % (span + 1)) - span / 2;
      tz = $signed(rand64() % (span + 1)) - span / 2;
      tx = tx - r.ox; ty = ty - r.oy; tz = tz - r.oz;
      sh = 0;
      while ((tx > 64'sd1073741823 || tx < -64'sd1073741823 ||
              ty > 64'sd1073741823 || ty < -64'sd1073741823 ||
              tz > 64'sd1073741823 || tz < -64'sd1073741823) && sh < 64) begin
        tx = tx >>> 1; ty = ty >>> 1; tz = tz >>> 1; sh++;
      end
      r.dx = DW'(tx); r.dy = DW'(ty); r.dz = DW'(tz);
      r.h = HGT_W'($signed($urandom_range(0, 4095)) - 2048);
      if (kind == 12) r.h = -$signed({1'b0, eq_rad[HGT_W-2:0]});
    end else if (kind == 13) begin
      r.dx = '0; r.dy = '0; r.dz = '0;
    end else if (kind == 14) begin
      r.dx = $signed($urandom_range(0, 6)) - 3;
      r.dy = $signed($urandom_range(0, 6)) - 3;
      r.dz = $signed($urandom_range(0, 6)) - 3;
    end
    return r;
  endfunction

  row_t directed[$];

  function automatic row_t mk(logic signed [CW-1:0] ox, oy, oz,
                              logic signed [DW-1:0] dx, dy, dz,
                              logic signed [HGT_W-1:0] h,
                              bit typed, status_t st);
    row_t w;
    w.ray = '{ox, oy, oz, dx, dy, dz, h};
    w.typed = typed;
    w.want = '{ox, oy, oz, st};
    return w;
  endfunction

  initial begin
    ray_t r;
    ground_t none;
    logic signed [CW-1:0] cmax, cmin;
    logic signed [DW-1:0] dmax, dmin;
    logic signed [HGT_W-1:0] hmax, hmin;
    cmax = {1'b0, {(CW-1){1'b1}}};
    cmin = {1'b1, {(CW-1){1'b0}}};
    dmax = {1'b0, {(DW-1){1'b1}}};
    dmin = {1'b1, {(DW-1){1'b0}}};
    hmax = {1'b0, {(HGT_W-1){1'b1}}};
    hmin = {1'b1, {(HGT_W-1){1'b0}}};
    none = '{'0, '0, '0, ST_HIT};

    // zero direction echoes the origin
    directed.push_back(mk(cmax, cmin, 48'sd5, '0, '0, '0, '0, 1, ST_ZERO));
    directed.push_back(mk(cmin, cmax, -48'sd1, '0, '0, '0, hmax, 1, ST_ZERO));
    // height cancels both reset radii: degenerate body, origin back as a miss
    directed.push_back(mk(48'sd1024, 48'sd7, 48'sd3, 32'sd1, 32'sd0, 32'sd0,
                          -40'sd256, 1, ST_MISS));
    directed.push_back(mk(48'sd1024, '0, '0, -32'sd1, '0, '0, '0, 0, ST_HIT));
    directed.push_back(mk('0, '0, -48'sd1000, '0, '0, 32'sd5, '0, 0, ST_HIT));
    directed.push_back(mk(48'sd1000, 48'sd1000, '0, '0, 32'sd1, '0, '0, 0, ST_HIT));
    directed.push_back(mk(48'sd256, -48'sd2000, '0, '0, 32'sd3, '0, '0, 0, ST_HIT));
    directed.push_back(mk('0, '0, '0, 32'sd1, 32'sd1, 32'sd1, '0, 0, ST_HIT));
    directed.push_back(mk(cmax, cmax, cmax, dmax, dmax, dmax, '0, 0, ST_HIT));
    directed.push_back(mk(cmin, cmin, cmin, dmin, dmin, dmin, '0, 0, ST_HIT));
    directed.push_back(mk(cmax, cmin, cmax, dmin, dmax, dmin, hmax, 0, ST_HIT));
    directed.push_back(mk(cmin, cmax, cmin, dmax, dmin, dmax, hmin, 0, ST_HIT));
    directed.push_back(mk(cmax, '0, '0, 32'sd1, '0, '0, '0, 0, ST_HIT));
    directed.push_back(mk(48'sd5000, '0, '0, -32'sd1, '0, '0, hmin, 0, ST_HIT));
    directed.push_back(mk(-48'sd1, -48'sd1, -48'sd1, -32'sd1, -32'sd1, -32'sd1,
                          -40'sd1, 0, ST_HIT));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_ray(directed[i].ray, directed[i].typed, directed[i].want);
    drain_pipe();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: ;
        1: begin
          write_radius(CFG_EQUATOR, RAD_W'(1));
          write_radius(CFG_POLAR, RAD_W'(1));
        end
        2: begin
          write_radius(CFG_EQUATOR, {RAD_W{1'b1}});
          write_radius(CFG_POLAR, {RAD_W{1'b1}});
        end
        3: begin
          // earth-sized oblate body
          write_radius(CFG_EQUATOR, RAD_W'(64'd6378137 * 256));
          write_radius(CFG_POLAR, RAD_W'(64'd6356752 * 256));
          write_radius(CFG_UNUSED, RAD_W'($urandom()));
        end
        default: begin
          write_radius(CFG_POLAR, RAD_W'($urandom_range(1, 1 << 30)));
          write_radius(CFG_EQUATOR, RAD_W'($urandom_range(1, 1 << 20)));
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = random_ray();
        send_ray(r, 0, none);
      end
      drain_pipe();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // compare every result against the oldest expected one
  always @(posedge clk) begin
    ground_t w;
    if (rst_n && out_valid) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d st=%0d", $time,
                 out_hit_x, out_hit_y, out_hit_z, out_status);
        fail_count++;
      end else begin
        w = pending_hits.pop_front();
        if (out_hit_x !== w.hx) begin
          $display("%0t: hit_x expected %0d actual %0d", $time, w.hx, out_hit_x);
          fail_count++;
        end
        if (out_hit_y !== w.hy) begin
          $display("%0t: hit_y expected %0d actual %0d", $time, w.hy, out_hit_y);
          fail_count++;
        end
        if (out_hit_z !== w.hz) begin
          $display("%0t: hit_z expected %0d actual %0d", $time, w.hz, out_hit_z);
          fail_count++;
        end
        if (out_status !== w.st) begin
          $display("%0t: status expected %0d actual %0d", $time, w.st, out_status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
rtl/core/rei_pkg.sv
rtl/core/rei_delay.sv
rtl/core/rei_mul.sv
rtl/core/rei_isqrt.sv
rtl/core/rei_div.sv
rtl/core/ray_ellipsoid_intersect_unit.sv
rtl/core/rei_checker.sv
tb/ray_ellipsoid_intersect_unit_tb.sv
